// ===== hdl/assert_macros.svh =====
// assertion macros for the dedup ring fifo checker
// each macro checks on the rising edge of clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define DRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold whenever a result is offered
`define DRF_ASSERT_OUT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) out_valid |-> (cond)) \
    else $error(msg);

`endif

// ===== hdl/drf_pkg.sv =====
// shared types and codes for the dedup ring fifo
// used by all hdl modules through scoped names; no dependencies
`timescale 1ns / 1ps

package drf_pkg;

  // default number of ring slots
  localparam int RING_SIZE_DEF = 1024;

  // request codes
  localparam logic [1:0] REQ_PUSH      = 2'd0;
  localparam logic [1:0] REQ_PUSH_ONCE = 2'd1;
  localparam logic [1:0] REQ_POP       = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one ring entry
  typedef struct packed {
    logic [63:0] handler;
    logic [63:0] data;
  } pair_t;

endpackage

// ===== hdl/drf_ring_mem.sv =====
// ring storage: one write port and one registered read port
// depends on drf_pkg for the entry type
`timescale 1ns / 1ps

module drf_ring_mem #(
  parameter int RING_SIZE = drf_pkg::RING_SIZE_DEF,
  localparam int PTR_W = $clog2(RING_SIZE)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [PTR_W-1:0]    waddr,
  input  drf_pkg::pair_t      wdata,
  input  logic [PTR_W-1:0]    raddr,
  output drf_pkg::pair_t      rdata
);

  drf_pkg::pair_t mem [RING_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/drf_match.sv =====
// shared pair comparator used by the compaction walk
// depends on drf_pkg for the entry type
`timescale 1ns / 1ps

module drf_match (
  input  drf_pkg::pair_t stored,
  input  drf_pkg::pair_t key,
  output logic           hit
);

  // both words must agree for a duplicate
  assign hit = (stored.handler == key.handler) && (stored.data == key.data);

endmodule

// ===== hdl/drf_seq.sv =====
// request sequencer: pointers, compaction walk, append, pop and result register
// depends on drf_pkg; drives drf_ring_mem and reads drf_match
`timescale 1ns / 1ps

module drf_seq #(
  parameter int RING_SIZE = drf_pkg::RING_SIZE_DEF,
  localparam int PTR_W = $clog2(RING_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  input  logic [63:0]      handler_id,
  input  logic [63:0]      data_word,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [63:0]      out_handler,
  output logic [63:0]      out_data,
  output logic             now_empty,
  // ring storage
  output logic             mem_we,
  output logic [PTR_W-1:0] mem_waddr,
  output drf_pkg::pair_t   mem_wdata,
  output logic [PTR_W-1:0] mem_raddr,
  input  drf_pkg::pair_t   mem_rdata,
  // comparator
  output drf_pkg::pair_t   cmp_key,
  input  logic             cmp_hit
);

  localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_APPEND,
    S_POP,
    S_NOP,
    S_WAIT_OUT
  } state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] rd, rd_next;
  logic [PTR_W-1:0] wr, wr_next;
  drf_pkg::pair_t   key;

  // finished result before it reaches the output register
  logic             done;
  logic [1:0]       res_status;
  drf_pkg::pair_t   res_pair;
  logic             res_empty;

  // result parked while the output register is occupied
  logic [1:0]       hold_status;
  drf_pkg::pair_t   hold_pair;
  logic             hold_empty;

  logic             slot_free;
  logic [PTR_W-1:0] head_inc;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign cmp_key   = key;
  assign head_inc  = ring_next(head);

  // next-state and storage access
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    rd_next    = rd;
    wr_next    = wr;
    mem_we     = 1'b0;
    mem_waddr  = wr;
    mem_wdata  = mem_rdata;
    mem_raddr  = tail;
    done       = 1'b0;
    res_status = drf_pkg::ST_OK;
    res_pair   = '0;
    case (state)
      S_IDLE: begin
        // read at tail ahead of a possible pop
        mem_raddr = tail;
        rd_next   = tail;
        wr_next   = tail;
        if (in_valid) begin
          case (req_type)
            drf_pkg::REQ_PUSH:      state_next = S_APPEND;
            drf_pkg::REQ_PUSH_ONCE: state_next = S_SCAN_RD;
            drf_pkg::REQ_POP:       state_next = S_POP;
            default:                state_next = S_NOP;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (rd == head) begin
          head_next  = wr;
          state_next = S_APPEND;
        end else begin
          mem_raddr  = rd;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        // keep entries that differ, moving them down over removed ones
        if (!cmp_hit) begin
          if (rd != wr) begin
            mem_we    = 1'b1;
            mem_waddr = wr;
            mem_wdata = mem_rdata;
          end
          wr_next = ring_next(wr);
        end
        rd_next    = ring_next(rd);
        state_next = S_SCAN_RD;
      end
      S_APPEND: begin
        done = 1'b1;
        if (head_inc == tail) begin
          res_status = drf_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = head;
          mem_wdata = key;
          head_next = head_inc;
        end
      end
      S_POP: begin
        done = 1'b1;
        if (head == tail) begin
          res_status = drf_pkg::ST_EMPTY;
        end else begin
          res_pair  = mem_rdata;
          tail_next = ring_next(tail);
        end
      end
      S_NOP: begin
        done = 1'b1;
      end
      S_WAIT_OUT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (done) begin
      state_next = slot_free ? S_IDLE : S_WAIT_OUT;
    end
  end

  assign res_empty = (head_next == tail_next);

  // state, pointers, request latch and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (done && slot_free) begin
        out_valid   <= 1'b1;
        status      <= res_status;
        out_handler <= res_pair.handler;
        out_data    <= res_pair.data;
        now_empty   <= res_empty;
      end else if (done) begin
        hold_status <= res_status;
        hold_pair   <= res_pair;
        hold_empty  <= res_empty;
      end else if (state == S_WAIT_OUT && slot_free) begin
        out_valid   <= 1'b1;
        status      <= hold_status;
        out_handler <= hold_pair.handler;
        out_data    <= hold_pair.data;
        now_empty   <= hold_empty;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
    rd <= rd_next;
    wr <= wr_next;
    if (state == S_IDLE && in_valid) begin
      key.handler <= handler_id;
      key.data    <= data_word;
    end
  end

endmodule

// ===== hdl/dedup_ring_fifo.sv =====
// top level of the dedup ring fifo: sequencer, ring storage and comparator
// depends on drf_pkg, drf_ring_mem, drf_match and drf_seq
`timescale 1ns / 1ps

// channel   signals                                         direction
// request   in_valid, in_ready, req_type, handler_id,       in
//           data_word
// result    out_valid, out_ready, status, out_handler,      out
//           out_data, now_empty
//
// push, pop and the unused code load the result register from the append, pop or nop state
// push-once walks the n queued entries, then appends: a read state fetches each
// over the one read port and a compare state checks it in the shared comparator
// reset clears head, tail and the result valid; storage is not cleared
// a result that cannot leave waits in a holding register and blocks new requests

module dedup_ring_fifo #(
  parameter int RING_SIZE = drf_pkg::RING_SIZE_DEF,
  localparam int PTR_W = $clog2(RING_SIZE)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [63:0] handler_id,
  input  logic [63:0] data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] out_handler,
  output logic [63:0] out_data,
  output logic        now_empty
);

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [PTR_W-1:0] mem_raddr;
  drf_pkg::pair_t   mem_wdata;
  drf_pkg::pair_t   mem_rdata;
  drf_pkg::pair_t   cmp_key;
  logic             cmp_hit;

  // request sequencer
  drf_seq #(.RING_SIZE(RING_SIZE)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .handler_id  (handler_id),
    .data_word   (data_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_handler (out_handler),
    .out_data    (out_data),
    .now_empty   (now_empty),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .cmp_key     (cmp_key),
    .cmp_hit     (cmp_hit)
  );

  // ring storage
  drf_ring_mem #(.RING_SIZE(RING_SIZE)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared duplicate comparator
  drf_match u_match (
    .stored (mem_rdata),
    .key    (cmp_key),
    .hit    (cmp_hit)
  );

endmodule

// ===== hdl/drf_checker.sv =====
// port-level checker for the dedup ring fifo, bound to the top level
// depends on drf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] out_handler,
  input logic [63:0] out_data,
  input logic        now_empty
);

  // a stalled result holds
  `DRF_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(now_empty),
    "stalled result changed")

  // one request at a time: busy right after a transfer
  `DRF_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // a rejected push means the ring held entries
  `DRF_ASSERT_OUT(a_full_not_empty, status != drf_pkg::ST_FULL || !now_empty,
    "full status with empty ring")

  // a failed pop leaves the ring empty
  `DRF_ASSERT_OUT(a_empty_pop, status != drf_pkg::ST_EMPTY || now_empty,
    "empty status with entries left")

  // only a successful pop carries a pair
  `DRF_ASSERT_OUT(a_zero_payload,
    status == drf_pkg::ST_OK || (out_handler == '0 && out_data == '0),
    "payload on failed request")

endmodule

bind dedup_ring_fifo drf_checker u_drf_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking testbench for dedup_ring_fifo: directed, full-ring, back-pressure and random tests
// predicts every result with a shadow ring and compares each transfer; needs drf_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS = drf_pkg::RING_SIZE_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int END_WAIT = 100;
  localparam int MAX_FILL_RANDOM = 40;
  localparam int RANDOM_ITEMS = 180;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] handler;
    logic [63:0] data;
    logic        empty;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = drf_pkg::REQ_PUSH;
  logic [63:0] handler_id = '0;
  logic [63:0] data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] out_handler;
  logic [63:0] out_data;
  logic        now_empty;

  // shadow copy of the ring
  bit [63:0] shadow_handler [SLOTS];
  bit [63:0] shadow_data [SLOTS];
  int        shadow_head = 0;
  int        shadow_tail = 0;

  result_t   results_due [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_until = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;

  // handler and data values that repeat so duplicates and partial matches occur
  logic [63:0] pool_h [3];
  logic [63:0] pool_d [2];

  dedup_ring_fifo dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .handler_id  (handler_id),
    .data_word   (data_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_handler (out_handler),
    .out_data    (out_data),
    .now_empty   (now_empty)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("dedup_ring_fifo verification failed");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off while cycle_cnt is below hold_until
  always @(posedge clk) begin
    if (cycle_cnt < hold_until) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic int next_slot(int p);
    return (p + 1 >= SLOTS) ? 0 : p + 1;
  endfunction

  function automatic int ring_count();
    return (shadow_head - shadow_tail + SLOTS) % SLOTS;
  endfunction

  // append one pair unless the ring is full
  function automatic logic [1:0] ring_append(logic [63:0] h, logic [63:0] d);
    int nh;
    nh = next_slot(shadow_head);
    if (nh == shadow_tail) return drf_pkg::ST_FULL;
    shadow_handler[shadow_head] = h;
    shadow_data[shadow_head] = d;
    shadow_head = nh;
    return drf_pkg::ST_OK;
  endfunction

  // expected result of one request, updating the shadow ring
  function automatic result_t ring_predict(logic [1:0] rt, logic [63:0] h, logic [63:0] d);
    result_t r;
    int rd;
    int wr;
    r = '0;
    r.status = drf_pkg::ST_OK;
    case (rt)
      drf_pkg::REQ_PUSH: begin
        r.status = ring_append(h, d);
      end
      drf_pkg::REQ_PUSH_ONCE: begin
        // compact in place, dropping exact matches, then append
        rd = shadow_tail;
        wr = shadow_tail;
        while (rd != shadow_head) begin
          if (shadow_handler[rd] != h || shadow_data[rd] != d) begin
            shadow_handler[wr] = shadow_handler[rd];
            shadow_data[wr] = shadow_data[rd];
            wr = next_slot(wr);
          end
          rd = next_slot(rd);
        end
        shadow_head = wr;
        r.status = ring_append(h, d);
      end
      drf_pkg::REQ_POP: begin
        if (shadow_head == shadow_tail) begin
          r.status = drf_pkg::ST_EMPTY;
        end else begin
          r.handler = shadow_handler[shadow_tail];
          r.data = shadow_data[shadow_tail];
          shadow_tail = next_slot(shadow_tail);
        end
      end
      default: ;
    endcase
    r.empty = (shadow_head == shadow_tail);
    return r;
  endfunction

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d handler %h data %h empty %0d",
                   status, out_handler, out_data, now_empty);
      end else begin
        want = results_due.pop_front();
        if (status !== want.status || out_handler !== want.handler ||
            out_data !== want.data || now_empty !== want.empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch exp: status %0d handler %h data %h empty %0d",
                     want.status, want.handler, want.data, want.empty);
            $display("         got: status %0d handler %h data %h empty %0d",
                     status, out_handler, out_data, now_empty);
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // send one request after a random gap and predict it once transferred
  task automatic send_req(input logic [1:0] rt, input logic [63:0] h, input logic [63:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    handler_id <= h;
    data_word <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(ring_predict(rt, h, d));
  endtask

  // sender pauses until every expected result has come
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // extremes, every request code, partial matches and compaction on a short ring
  task automatic test_directed();
    logic [63:0] a;
    logic [63:0] b;
    a = rand64();
    b = rand64();
    send_req(drf_pkg::REQ_POP, rand64(), rand64());
    send_req(REQ_UNUSED, '1, '1);
    send_req(drf_pkg::REQ_PUSH, '0, '0);
    send_req(drf_pkg::REQ_PUSH, '1, '1);
    send_req(drf_pkg::REQ_PUSH, '1, '0);
    send_req(drf_pkg::REQ_PUSH, '0, '1);
    send_req(drf_pkg::REQ_PUSH, '1, '1);
    send_req(REQ_UNUSED, '0, '0);
    send_req(drf_pkg::REQ_PUSH_ONCE, '1, '1);
    send_req(drf_pkg::REQ_PUSH_ONCE, a, b);
    send_req(drf_pkg::REQ_PUSH_ONCE, '0, '0);
    repeat (6) send_req(drf_pkg::REQ_POP, '1, '1);
    send_req(drf_pkg::REQ_PUSH_ONCE, a, b);
    send_req(drf_pkg::REQ_POP, '0, '0);
    send_req(drf_pkg::REQ_POP, a, b);
  endtask

  // fill to capacity, hit the full status and compaction on a full ring,
  // then collapse the filler with one push-once and drain the rest
  task automatic test_full_ring();
    logic [63:0] dup_h;
    logic [63:0] dup_d;
    logic [63:0] fill_h;
    logic [63:0] fill_d;
    dup_h = rand64();
    dup_d = rand64();
    fill_h = rand64();
    fill_d = rand64();
    for (int i = 0; i < SLOTS - 1; i++) begin
      if (i % 300 == 7) send_req(drf_pkg::REQ_PUSH, dup_h, dup_d);
      else if (i % 50 == 3) send_req(drf_pkg::REQ_PUSH, rand64(), 64'(i));
      else send_req(drf_pkg::REQ_PUSH, fill_h, fill_d);
    end
    send_req(drf_pkg::REQ_PUSH, rand64(), rand64());
    send_req(drf_pkg::REQ_PUSH_ONCE, rand64(), rand64());
    send_req(drf_pkg::REQ_PUSH_ONCE, dup_h, dup_d);
    send_req(drf_pkg::REQ_PUSH_ONCE, dup_h, dup_d);
    while (ring_count() < SLOTS - 1) send_req(drf_pkg::REQ_PUSH, rand64(), rand64());
    send_req(drf_pkg::REQ_PUSH, dup_h, dup_d);
    send_req(drf_pkg::REQ_PUSH_ONCE, fill_h, fill_d);
    while (ring_count() > 0) send_req(drf_pkg::REQ_POP, rand64(), rand64());
    send_req(drf_pkg::REQ_POP, rand64(), rand64());
  endtask

  // receiver holds off while the sender keeps offering, so the block stalls its input
  task automatic test_backpressure();
    hold_until = cycle_cnt + 400;
    for (int i = 0; i < 10; i++) begin
      send_req((i % 3 == 2) ? drf_pkg::REQ_POP : drf_pkg::REQ_PUSH_ONCE,
               pool_h[i % 3], pool_d[i % 2]);
    end
  endtask

  // random mix that keeps the ring short, with repeated values for duplicates
  task automatic test_random(input int n_items);
    int occ;
    int r;
    int pop_pct;
    logic [1:0] rt;
    logic [63:0] h;
    logic [63:0] d;
    for (int i = 0; i < n_items; i++) begin
      occ = ring_count();
      r = $urandom_range(99);
      pop_pct = (occ < 4) ? 20 : ((occ > 24) ? 60 : 40);
      if (r < 3) rt = REQ_UNUSED;
      else if (occ >= MAX_FILL_RANDOM || r < 3 + pop_pct) rt = drf_pkg::REQ_POP;
      else if ($urandom_range(1) == 1) rt = drf_pkg::REQ_PUSH;
      else rt = drf_pkg::REQ_PUSH_ONCE;
      if ($urandom_range(9) < 7) begin
        h = pool_h[$urandom_range(2)];
        d = pool_d[$urandom_range(1)];
      end else begin
        h = rand64();
        d = rand64();
      end
      send_req(rt, h, d);
    end
  endtask

  initial begin
    pool_h[0] = '0;
    pool_h[1] = '1;
    pool_h[2] = rand64();
    pool_d[0] = rand64();
    pool_d[1] = '1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    test_directed();
    wait_results();
    test_full_ring();
    wait_results();
    test_backpressure();
    wait_results();

    set_idling(0, 0);
    test_random(RANDOM_ITEMS);
    wait_results();
    set_idling(82, 0);
    test_random(RANDOM_ITEMS);
    wait_results();
    set_idling(0, 82);
    test_random(RANDOM_ITEMS);
    wait_results();
    set_idling(12, 12);
    test_random(RANDOM_ITEMS);
    wait_results();

    // let any stray result show up
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("dedup_ring_fifo verification clean");
    end else begin
      $display("dedup_ring_fifo verification failed");
    end
    $finish;
  end

endmodule
